@@ hdl/fnvch_pkg.sv @@
// Shared types, constants and hash helpers for the FNV-1a content hash combiner.
// Used by the front stage, the item queue, the back stage and the top level.
// No dependencies.
package fnvch_pkg;

    localparam int LENGTH_BITS    = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] FNV_BASIS     = 64'd14695981039346656037;
    // The FNV prime is 2^40 + 0x1b3, so the fold is a handful of shifted adds.
    localparam int          FNV_PRIME_SHIFT = 40;

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int          MIX_SHIFT_A = 30;
    localparam int          MIX_SHIFT_B = 27;
    localparam int          MIX_SHIFT_C = 31;

    // What the end of an item asks of the back stage.
    localparam logic [1:0] END_NONE = 2'd0;
    localparam logic [1:0] END_FILE = 2'd1;
    localparam logic [1:0] END_TEXT = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic [1:0] end_kind;
    } item_t;

    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ 64'(b);
        // 0x1b3 has bits 8, 7, 5, 4, 1 and 0 set.
        return (x << FNV_PRIME_SHIFT) + (x << 8) + (x << 7) + (x << 5)
             + (x << 4) + (x << 1) + x;
    endfunction

endpackage

@@ hdl/fnvch_front.sv @@
// Front stage of the FNV-1a content hash combiner: accepts input transactions,
// drops items that carry neither a byte nor an entry end, and tags the rest.
// Depends on fnvch_pkg.
module fnvch_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic [1:0]          s_tuser,
    output logic                push,
    output fnvch_pkg::item_t    push_item,
    input  logic                queue_full
);

    logic             hold_valid_reg;
    logic             hold_valid_next;
    fnvch_pkg::item_t hold_item_reg;
    fnvch_pkg::item_t hold_item_next;
    logic             accept;

    assign push     = hold_valid_reg && !queue_full;
    assign s_tready = !hold_valid_reg || !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign push_item = hold_item_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_item_next  = hold_item_reg;
        if (push) begin
            hold_valid_next = 1'b0;
        end
        // An item with no byte and no end changes nothing downstream.
        if (accept && (s_tuser[0] || s_tlast)) begin
            hold_valid_next          = 1'b1;
            hold_item_next.data_byte = s_tdata;
            hold_item_next.has_byte  = s_tuser[0];
            if (!s_tlast) begin
                hold_item_next.end_kind = fnvch_pkg::END_NONE;
            end else if (s_tuser[1]) begin
                hold_item_next.end_kind = fnvch_pkg::END_TEXT;
            end else begin
                hold_item_next.end_kind = fnvch_pkg::END_FILE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_item_reg <= hold_item_next;
    end

endmodule

@@ hdl/fnvch_queue.sv @@
// Short FIFO of tagged items between the front and back stages.
// Depends on fnvch_pkg.
module fnvch_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  fnvch_pkg::item_t push_item,
    output logic             full,
    input  logic             pop,
    output fnvch_pkg::item_t pop_item,
    output logic             empty
);

    fnvch_pkg::item_t                          store [fnvch_pkg::QUEUE_DEPTH];
    logic [fnvch_pkg::QUEUE_PTR_BITS-1:0]      wr_ptr_reg;
    logic [fnvch_pkg::QUEUE_PTR_BITS-1:0]      rd_ptr_reg;
    logic [fnvch_pkg::QUEUE_PTR_BITS:0]        count_reg;
    logic                                      do_push;
    logic                                      do_pop;

    assign full     = (count_reg == (fnvch_pkg::QUEUE_PTR_BITS+1)'(fnvch_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = store[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/fnvch_back.sv @@
// Back stage: folds bytes into the running FNV-1a hash, finishes entries
// (terminator fold or splitmix64 size term) and holds the result register.
// Depends on fnvch_pkg.
module fnvch_back (
    input  logic             aclk,
    input  logic             aresetn,
    output logic             pop,
    input  fnvch_pkg::item_t pop_item,
    input  logic             queue_empty,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [127:0]     m_tdata
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_TERM = 2'd1;
    localparam logic [1:0] ST_MIX  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;
    localparam logic [1:0] STEP_SUM = 2'd3;

    logic [1:0]                        state_reg;
    logic [63:0]                       hash_reg;
    logic [fnvch_pkg::LENGTH_BITS-1:0] len_reg;
    logic [63:0]                       total_reg;
    logic [63:0]                       size_reg;
    logic [63:0]                       op_reg;
    logic [63:0]                       acc_reg;
    logic [63:0]                       prod_reg;
    logic [1:0]                        step_reg;
    logic                              phase_reg;
    logic                              out_valid_reg;
    logic [63:0]                       out_entry_reg;
    logic [63:0]                       out_total_reg;

    logic [fnvch_pkg::LENGTH_BITS-1:0] len_upd;
    logic [63:0]                       len_wide;
    logic [63:0]                       hash_upd;
    logic [63:0]                       mix_const;
    logic [31:0]                       mul_a;
    logic [31:0]                       mul_b;
    logic [63:0]                       acc_sum;
    logic                              out_free;
    logic                              load_out;
    logic [63:0]                       total_new;

    assign pop      = (state_reg == ST_RUN) && !queue_empty;
    assign out_free = !out_valid_reg || m_tready;
    assign load_out = (state_reg == ST_DONE) && out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_total_reg, out_entry_reg};

    assign len_upd  = pop_item.has_byte ? len_reg + fnvch_pkg::LENGTH_BITS'(1) : len_reg;
    assign len_wide = 64'(len_upd);
    assign hash_upd = pop_item.has_byte ? fnvch_pkg::fnv_fold(hash_reg, pop_item.data_byte)
                                        : hash_reg;

    assign mix_const = phase_reg ? fnvch_pkg::MIX_C2 : fnvch_pkg::MIX_C1;
    assign acc_sum   = acc_reg + {prod_reg[31:0], 32'b0};
    assign total_new = total_reg ^ hash_reg ^ size_reg;

    // The 64-bit product modulo 2^64 needs three 32x32 partial products.
    always_comb begin
        case (step_reg)
            STEP_LL: begin
                mul_a = op_reg[31:0];
                mul_b = mix_const[31:0];
            end
            STEP_LH: begin
                mul_a = op_reg[31:0];
                mul_b = mix_const[63:32];
            end
            default: begin
                mul_a = op_reg[63:32];
                mul_b = mix_const[31:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            hash_reg      <= fnvch_pkg::FNV_BASIS;
            len_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= STEP_LL;
            phase_reg     <= 1'b0;
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_RUN: begin
                    if (pop) begin
                        hash_reg <= hash_upd;
                        len_reg  <= len_upd;
                        case (pop_item.end_kind)
                            fnvch_pkg::END_TEXT: begin
                                state_reg <= ST_TERM;
                            end
                            fnvch_pkg::END_FILE: begin
                                op_reg    <= len_wide ^ (len_wide >> fnvch_pkg::MIX_SHIFT_A);
                                step_reg  <= STEP_LL;
                                phase_reg <= 1'b0;
                                state_reg <= ST_MIX;
                            end
                            default: begin
                                state_reg <= ST_RUN;
                            end
                        endcase
                    end
                end
                ST_TERM: begin
                    hash_reg  <= fnvch_pkg::fnv_fold(hash_reg, 8'd0);
                    size_reg  <= 64'(len_reg);
                    state_reg <= ST_DONE;
                end
                ST_MIX: begin
                    prod_reg <= 64'(mul_a) * 64'(mul_b);
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_LH) begin
                        acc_reg <= prod_reg;
                    end else if (step_reg == STEP_HL) begin
                        acc_reg <= acc_sum;
                    end else if (step_reg == STEP_SUM) begin
                        if (!phase_reg) begin
                            op_reg    <= acc_sum ^ (acc_sum >> fnvch_pkg::MIX_SHIFT_B);
                            phase_reg <= 1'b1;
                        end else begin
                            size_reg  <= acc_sum ^ (acc_sum >> fnvch_pkg::MIX_SHIFT_C);
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_entry_reg <= hash_reg;
                        out_total_reg <= total_new;
                        total_reg     <= total_new;
                        hash_reg      <= fnvch_pkg::FNV_BASIS;
                        len_reg       <= '0;
                        state_reg     <= ST_RUN;
                    end
                end
                default: begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

endmodule

@@ hdl/fnv1a_content_hash_combiner_unit.sv @@
// Top level of the FNV-1a content hash combiner.
// Instantiates fnvch_front, fnvch_queue and fnvch_back; depends on fnvch_pkg.
//
// Usage:
//   The slave channel carries one byte per transaction, grouped into entries.
//   tlast marks the last transaction of an entry; tuser[0] says the byte is
//   present (an entry may end on a transaction without a byte) and tuser[1]
//   on the last transaction selects a text entry over file contents.
//   Transactions without a byte and without tlast are dropped.
//   The master channel gives one transaction per finished entry: the entry
//   hash and the combined total after that entry.
// Throughput and entry ends:
//   Byte transactions are taken one per cycle while the queue has room. A text
//   entry end passes through the terminator fold and the result load in the
//   back stage; a file entry end passes through the splitmix64 finalizer,
//   which runs its two 64-bit multiplies as three 32x32 partial products each
//   on one multiplier, and then the result load. A four-entry queue lets
//   bytes keep arriving meanwhile.
// Reset and stalls:
//   Synchronous active-low reset sets the hash to the offset basis and clears
//   the length, the total and the queue. When the master side stalls, the
//   result register holds, the back stage waits and the queue fills, and
//   then s_tready drops.
module fnv1a_content_hash_combiner_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,
    input  logic [1:0]   s_tuser,   // [0] byte_valid, [1] is_text
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [63:0] entry_hash, [127:64] total_hash
);

    logic             push;
    fnvch_pkg::item_t push_item;
    logic             queue_full;
    logic             pop;
    fnvch_pkg::item_t pop_item;
    logic             queue_empty;

    fnvch_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    fnvch_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    fnvch_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop         (pop),
        .pop_item    (pop_item),
        .queue_empty (queue_empty),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

@@ bench/fnv1a_content_hash_combiner_unit_test.sv @@
// Self-checking testbench for fnv1a_content_hash_combiner_unit.
// Drives byte transactions, predicts each entry digest in SystemVerilog and compares.
// Depends on fnvch_pkg and the block's RTL only.
module fnv1a_content_hash_combiner_unit_test;

    localparam logic [63:0] FNV_OFFSET     = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_MULT       = 64'h00000100000001b3;
    localparam bit          KIND_FILE      = 1'b0;
    localparam bit          KIND_TEXT      = 1'b1;
    localparam int          TOTAL_ITEMS    = 1650;
    localparam int          TAIL_ITEMS     = 200;
    localparam int          LONG_HOLD      = 64;
    localparam int          DRAIN_CYCLES   = 30;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          DIRECTED_COUNT = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       text;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [63:0] entry_hash;
        logic [63:0] total_hash;
    } digest_t;

    // One directed transaction; known marks rows whose digest is typed in here.
    typedef struct packed {
        logic [7:0]  data;
        logic        has_byte;
        logic        text;
        logic        last;
        logic        known;
        logic [63:0] want_entry;
        logic [63:0] want_total;
    } stim_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // [7:0] data_byte
    logic         s_tlast;
    logic [1:0]   s_tuser;   // [0] byte_valid, [1] is_text
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // [63:0] entry_hash, [127:64] total_hash

    fnv1a_content_hash_combiner_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predictor state.
    logic [63:0]                       fold_hash = FNV_OFFSET;
    logic [fnvch_pkg::LENGTH_BITS-1:0] fold_len = '0;
    logic [63:0]                       combined_total = '0;

    digest_t owed_digests[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      items_sent = 0;
    int      noise_items = 0;
    int      file_ends = 0;
    int      text_ends = 0;
    int      longest_entry = 0;
    int      stall_cycles = 0;
    int      idle_pct = 0;
    bit      long_hold_req = 1'b0;

    stim_row_t directed_rows [0:DIRECTED_COUNT-1] = '{
        // Empty file right after reset: basis hash, zero size term.
        '{8'h00, 1'b0, KIND_FILE, 1'b1, 1'b1, 64'hcbf29ce484222325, 64'hcbf29ce484222325},
        // Empty text: the terminator alone.
        '{8'h00, 1'b0, KIND_TEXT, 1'b1, 1'b1, 64'haf63bd4c8601b7df, 64'h649121a8022394fa},
        '{8'h5a, 1'b0, KIND_TEXT, 1'b0, 1'b0, 64'd0, 64'd0},
        '{8'h00, 1'b1, KIND_FILE, 1'b1, 1'b0, 64'd0, 64'd0},
        '{8'hff, 1'b1, KIND_TEXT, 1'b1, 1'b0, 64'd0, 64'd0},
        '{8'h61, 1'b1, KIND_TEXT, 1'b0, 1'b0, 64'd0, 64'd0},
        '{8'h00, 1'b1, KIND_FILE, 1'b0, 1'b0, 64'd0, 64'd0},
        '{8'h62, 1'b1, KIND_TEXT, 1'b0, 1'b0, 64'd0, 64'd0},
        '{8'h00, 1'b0, KIND_TEXT, 1'b1, 1'b0, 64'd0, 64'd0},
        '{8'hff, 1'b1, KIND_FILE, 1'b0, 1'b0, 64'd0, 64'd0},
        '{8'h80, 1'b1, KIND_TEXT, 1'b0, 1'b0, 64'd0, 64'd0},
        '{8'h01, 1'b1, KIND_FILE, 1'b0, 1'b0, 64'd0, 64'd0},
        '{8'h7f, 1'b1, KIND_FILE, 1'b1, 1'b0, 64'd0, 64'd0},
        '{8'h33, 1'b0, KIND_FILE, 1'b0, 1'b0, 64'd0, 64'd0},
        '{8'hff, 1'b1, KIND_TEXT, 1'b0, 1'b0, 64'd0, 64'd0},
        '{8'hff, 1'b1, KIND_FILE, 1'b0, 1'b0, 64'd0, 64'd0},
        '{8'h00, 1'b0, KIND_FILE, 1'b1, 1'b0, 64'd0, 64'd0},
        '{8'h00, 1'b1, KIND_TEXT, 1'b1, 1'b0, 64'd0, 64'd0},
        '{8'h00, 1'b0, KIND_FILE, 1'b1, 1'b0, 64'd0, 64'd0},
        '{8'h00, 1'b0, KIND_TEXT, 1'b1, 1'b0, 64'd0, 64'd0}
    };

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * FNV_MULT;
    endfunction

    function automatic logic [63:0] splitmix_finalize(input logic [63:0] x);
        x = (x ^ (x >> 30)) * 64'hbf58476d1ce4e5b9;
        x = (x ^ (x >> 27)) * 64'h94d049bb133111eb;
        return x ^ (x >> 31);
    endfunction

    // Folds one accepted transaction into the predicted state; returns 1 when it ends an entry.
    function automatic bit absorb_item(input byte_item_t it, output digest_t d);
        logic [63:0] size_term;
        d = '0;
        if (it.has_byte) begin
            fold_hash = fnv_step(fold_hash, it.data);
            fold_len  = fold_len + 1'b1;
        end
        if (!it.last) return 1'b0;
        if (it.text == KIND_TEXT) begin
            fold_hash = fnv_step(fold_hash, 8'h00);
            size_term = 64'(fold_len);
        end else begin
            size_term = splitmix_finalize(64'(fold_len));
        end
        combined_total = combined_total ^ fold_hash ^ size_term;
        d.entry_hash   = fold_hash;
        d.total_hash   = combined_total;
        fold_hash      = FNV_OFFSET;
        fold_len       = '0;
        return 1'b1;
    endfunction

    always #2 aclk = ~aclk;

    // Offers one transaction, optionally after a short gap, and predicts it once accepted.
    task automatic offer(input byte_item_t it, input bit known, input digest_t known_digest);
        int      gap;
        digest_t d;
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= it.data;
        s_tlast  <= it.last;
        s_tuser  <= {it.text, it.has_byte};
        do @(posedge aclk); while (!s_tready);
        if (it.has_byte || it.last) items_sent++;
        else noise_items++;
        if (absorb_item(it, d)) begin
            owed_digests.push_back(known ? known_digest : d);
            if (it.text == KIND_TEXT) text_ends++;
            else file_ends++;
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (owed_digests.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int         k;
        int         len;
        int         r;
        int         short_left;
        int         next_retune;
        bit         hold_done;
        bit         pause_done;
        bit         end_on_byte;
        bit         end_text;
        byte_item_t it;
        digest_t    known_digest;

        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = '0;
        short_left  = 0;
        next_retune = 150;
        hold_done   = 1'b0;
        pause_done  = 1'b0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idle_pct = 25;
        for (k = 0; k < DIRECTED_COUNT; k++) begin
            it = '{directed_rows[k].data, directed_rows[k].has_byte,
                   directed_rows[k].text, directed_rows[k].last};
            known_digest = '{directed_rows[k].want_entry, directed_rows[k].want_total};
            offer(it, directed_rows[k].known, known_digest);
        end
        wait_drained();

        while (items_sent + noise_items < TOTAL_ITEMS) begin
            if (items_sent >= next_retune) begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    2: idle_pct = 30;
                    default: idle_pct = 50;
                endcase
                next_retune += 150;
            end
            // Stall the result side for a long stretch while short entries pour in.
            if (!hold_done && items_sent >= 300) begin
                long_hold_req = 1'b1;
                short_left    = 30;
                idle_pct      = 0;
                hold_done     = 1'b1;
            end
            if (!pause_done && items_sent >= 900) begin
                wait_drained();
                pause_done = 1'b1;
            end
            if (items_sent + noise_items >= TOTAL_ITEMS - TAIL_ITEMS) idle_pct = 0;

            r = $urandom_range(0, 99);
            if (short_left > 0) begin
                len = $urandom_range(0, 1);
                short_left--;
            end else if (r < 70) begin
                len = $urandom_range(0, 6);
            end else if (r < 97) begin
                len = $urandom_range(7, 32);
            end else begin
                len = $urandom_range(33, 260);
            end
            if (len > longest_entry) longest_entry = len;
            end_on_byte = (len > 0) && ($urandom_range(0, 9) < 7);
            end_text    = 1'($urandom_range(0, 1));

            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    it = '{8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b0};
                    offer(it, 1'b0, '0);
                end
                case ($urandom_range(0, 7))
                    0: it.data = 8'h00;
                    1: it.data = 8'hff;
                    default: it.data = 8'($urandom_range(0, 255));
                endcase
                it.has_byte = 1'b1;
                it.last     = end_on_byte && (k == len - 1);
                it.text     = it.last ? end_text : 1'($urandom_range(0, 1));
                offer(it, 1'b0, '0);
            end
            if (!end_on_byte) begin
                it = '{8'($urandom_range(0, 255)), 1'b0, end_text, 1'b1};
                offer(it, 1'b0, '0);
            end
        end

        wait_drained();
        $display("Covered %0d byte and end transactions plus %0d empty ones, %0d entries",
                 items_sent, noise_items, file_ends + text_ends);
        $display("(%0d file, %0d text), %0d digests checked, longest entry %0d bytes.",
                 file_ends, text_ends, results_seen, longest_entry);
        if (mismatches == 0 && owed_digests.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result-side backpressure: short random stalls, plus one long hold on request.
    initial begin : sink
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                hold = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        digest_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (owed_digests.size() == 0) begin
                $display("%0t: unexpected result, actual entry_hash %h total_hash %h",
                         $time, m_tdata[63:0], m_tdata[127:64]);
                mismatches++;
            end else begin
                want = owed_digests.pop_front();
                if (m_tdata[63:0] !== want.entry_hash) begin
                    $display("%0t: entry_hash expected %h actual %h",
                             $time, want.entry_hash, m_tdata[63:0]);
                    mismatches++;
                end
                if (m_tdata[127:64] !== want.total_hash) begin
                    $display("%0t: total_hash expected %h actual %h",
                             $time, want.total_hash, m_tdata[127:64]);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if neither channel completes a transaction for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, owed_digests.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
